// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sorter RTL.
// Each macro wraps a clocked property on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/isk_pkg.sv -----
// Shared types and constants for the stable key sorter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package isk_pkg;

	localparam int KEY_W     = 32;
	localparam int MAX_KEYS  = 64;
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// One queued transaction: a key and its end-of-set mark.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic                    set_end;
	} q_entry_t;

	// Handshake between the front queue and the sort engine.
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	typedef enum logic {
		ST_INSERT,
		ST_EMIT
	} back_state_t;

endpackage

// ----- rtl/isk_front.sv -----
// Input side of the sorter: accepts transactions and queues them.
// Depends on isk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isk_front import isk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [KEY_W-1:0] key_in,
	input  logic                    set_end,
	output q_head_t                 head,
	input  logic                    pop
);

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              do_pop;

	assign in_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].key     <= key_in;
			mem_q[wr_ptr_q].set_end <= set_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_q_cnt_range, cnt_q <= QCNT_W'(QDEPTH), "queue count overflow")
	`ASSERT_IMPLY(a_q_pop_nonempty, pop, cnt_q != '0, "pop from empty queue")

endmodule

// ----- rtl/isk_back.sv -----
// Sort engine: a key cell chain that inserts one key per cycle unless emitting and
// shifts the sorted set out on end of set. Depends on isk_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isk_back import isk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_head_t                 head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [KEY_W-1:0] key_out,
	output logic                    last_out
);

	back_state_t             state_q;
	back_state_t             state_d;
	logic [CNT_W-1:0]        key_count_q;
	logic signed [KEY_W-1:0] cell_q [MAX_KEYS];
	logic signed [KEY_W-1:0] cell_d [MAX_KEYS];
	logic [MAX_KEYS-1:0]     less;
	logic [MAX_KEYS-1:0]     take;
	logic                    room;
	logic                    out_free;
	logic                    do_insert;
	logic                    do_emit;
	logic                    out_valid_q;
	logic signed [KEY_W-1:0] key_out_q;
	logic                    last_out_q;

	assign room     = (key_count_q < CNT_W'(MAX_KEYS));
	assign out_free = !out_valid_q || out_ready;

	// Each cell compares itself against the incoming key; the chain is
	// sorted, so the cells holding larger keys form a contiguous top run.
	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			less[i] = (CNT_W'(i) < key_count_q) && (head.entry.key < cell_q[i]);
			take[i] = less[i] || (CNT_W'(i) == key_count_q);
		end
	end

	always_comb begin
		cell_d = cell_q;
		if (do_insert && room) begin
			if (take[0])
				cell_d[0] = head.entry.key;
			for (int i = 1; i < MAX_KEYS; i++) begin
				if (take[i])
					cell_d[i] = less[i-1] ? cell_q[i-1] : head.entry.key;
			end
		end else if (do_emit) begin
			for (int i = 0; i < MAX_KEYS - 1; i++)
				cell_d[i] = cell_q[i+1];
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INSERT: begin
				if (head.valid && head.entry.set_end)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (do_emit && (key_count_q == CNT_W'(1)))
					state_d = ST_INSERT;
			end
			default: state_d = ST_INSERT;
		endcase
	end

	// FSM outputs
	always_comb begin
		do_insert = 1'b0;
		do_emit   = 1'b0;
		case (state_q)
			ST_INSERT: do_insert = head.valid;
			ST_EMIT:   do_emit   = out_free;
			default: begin
				do_insert = 1'b0;
				do_emit   = 1'b0;
			end
		endcase
	end

	assign pop = do_insert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INSERT;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert && room)
				key_count_q <= key_count_q + CNT_W'(1);
			else if (do_emit)
				key_count_q <= key_count_q - CNT_W'(1);
			if (do_emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			key_out_q  <= cell_q[0];
			last_out_q <= (key_count_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign key_out   = key_out_q;
	assign last_out  = last_out_q;

	`ASSERT_ALWAYS(a_count_range, key_count_q <= CNT_W'(MAX_KEYS), "key count above capacity")
	`ASSERT_IMPLY(a_emit_nonempty, state_q == ST_EMIT, key_count_q != '0, "emitting an empty set")
	`ASSERT_IMPLY(a_chain_sorted, (state_q == ST_INSERT) && (key_count_q > CNT_W'(1)), !(cell_q[1] < cell_q[0]), "cell chain out of order")
	`ASSERT_NEXT(a_last_clears, do_emit && (key_count_q == CNT_W'(1)), (key_count_q == '0) && last_out_q, "last key did not clear the set")

endmodule

// ----- rtl/insertion_sort_keys.sv -----
//  channel | signals                          | dir | transaction
//  --------+----------------------------------+-----+------------------------------
//  in      | in_valid in_ready key_in set_end | in  | one key, set_end on last key
//  out     | out_valid out_ready key_out      | out | one sorted key, last_out on
//          | last_out                         |     | final key of the run
//
// Insert: one key per cycle, outside the end-of-set shift-out, through the
// compare-and-shift cell chain, once the key has been registered in the queue.
// End of set: the chain shifts the held keys out through the output register;
// each key passes the queue, an insert, a shift and the output register on its
// way from key in to key out.
// A 4-entry input queue lets keys arrive while the chain is emitting; in_ready
// drops once it fills. A low out_ready stalls the shift-out.
// Reset clears the queue, key count and output valid; cell contents are
// only read below the count. Keys beyond MAX_KEYS are dropped.
// Top level of the stable key sorter; depends on isk_pkg, isk_front, isk_back.
`timescale 1ns / 1ps

module insertion_sort_keys import isk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [KEY_W-1:0] key_in,
	input  logic                    set_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [KEY_W-1:0] key_out,
	output logic                    last_out
);

	q_head_t head;
	logic    pop;

	isk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.key_in   (key_in),
		.set_end  (set_end),
		.head     (head),
		.pop      (pop)
	);

	isk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_out   (key_out),
		.last_out  (last_out)
	);

endmodule
